// ===== rtl/fbpa_pkg.sv =====
// Shared types, widths and codes for the fixed block pool allocator.
// Used by every module in rtl/; depends on nothing else.
package fbpa_pkg;

    localparam int N_POOLS     = 4;
    localparam int POOL_W      = 2;
    localparam int BS_W        = 9;
    localparam int SIZE_W      = 9;
    localparam int ADDR_W      = 15;
    localparam int SLOT_W      = 5;
    localparam int SLOT_CNT_W  = 6;
    localparam int MAP_W       = 32;
    localparam int BASE_W      = 17;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int DIV_STEPS   = SLOT_W;

    // Default slot counts per pool
    localparam int POOL0_SLOTS_DEF = 20;
    localparam int POOL1_SLOTS_DEF = 10;
    localparam int POOL2_SLOTS_DEF = 5;
    localparam int POOL3_SLOTS_DEF = 5;

    // Block size register reset values
    localparam logic [BS_W-1:0] POOL0_BS_RST = 9'd64;
    localparam logic [BS_W-1:0] POOL1_BS_RST = 9'd128;
    localparam logic [BS_W-1:0] POOL2_BS_RST = 9'd256;
    localparam logic [BS_W-1:0] POOL3_BS_RST = 9'd256;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POOL0_BLOCK_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL1_BLOCK_SIZE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POOL2_BLOCK_SIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POOL3_BLOCK_SIZE = 3'd3;

    // Request kinds
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOFIT = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

    localparam logic [POOL_W-1:0] LAST_POOL = POOL_W'(N_POOLS - 1);

    // Bitmap update and lookup, one pool at a time
    typedef struct packed {
        logic              set;
        logic              clr;
        logic [POOL_W-1:0] pool;
        logic [SLOT_W-1:0] slot;
    } bm_cmd_t;

    typedef struct packed {
        logic              full;
        logic [SLOT_W-1:0] first_free;
    } bm_stat_t;

    function automatic logic [MAP_W-1:0] slot_mask(input int n);
        logic [MAP_W-1:0] m;
        m = '0;
        for (int i = 0; i < MAP_W; i++) begin
            if (i < n) begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

// ===== rtl/fbpa_muladd.sv =====
// Shared multiply-add unit: base + count * block size.
// Depends on fbpa_pkg.
module fbpa_muladd (
    input  logic [fbpa_pkg::BASE_W-1:0]     base,
    input  logic [fbpa_pkg::SLOT_CNT_W-1:0] count,
    input  logic [fbpa_pkg::BS_W-1:0]       block_size,
    output logic [fbpa_pkg::BASE_W-1:0]     sum
);
    import fbpa_pkg::*;

    localparam int PROD_W = SLOT_CNT_W + BS_W;

    logic [PROD_W-1:0] prod;

    assign prod = PROD_W'(count) * PROD_W'(block_size);
    assign sum  = base + BASE_W'(prod);

endmodule

// ===== rtl/fbpa_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient below 2**SLOT_W.
// Depends on fbpa_pkg.
module fbpa_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [fbpa_pkg::ADDR_W-1:0]  dividend,
    input  logic [fbpa_pkg::BS_W-1:0]    divisor,
    output logic                         done,
    output logic [fbpa_pkg::SLOT_W-1:0]  quotient,
    output logic [fbpa_pkg::ADDR_W-1:0]  remainder
);
    import fbpa_pkg::*;

    localparam int DSR_W = BS_W + DIV_STEPS - 1;
    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic [ADDR_W-1:0] rem_reg;
    logic [DSR_W-1:0]  dsr_reg;
    logic [SLOT_W-1:0] quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic              take;

    assign take = rem_reg >= ADDR_W'(dsr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(DIV_STEPS);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend;
            dsr_reg <= {divisor, (DIV_STEPS-1)'(0)};
            quo_reg <= '0;
        end else if (run_reg) begin
            if (take) begin
                rem_reg <= rem_reg - ADDR_W'(dsr_reg);
            end
            quo_reg <= {quo_reg[SLOT_W-2:0], take};
            dsr_reg <= dsr_reg >> 1;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/fbpa_bitmaps.sv =====
// Occupancy bitmaps of the four pools with full flag and lowest free slot.
// Depends on fbpa_pkg.
module fbpa_bitmaps #(
    parameter int POOL0_SLOTS = fbpa_pkg::POOL0_SLOTS_DEF,
    parameter int POOL1_SLOTS = fbpa_pkg::POOL1_SLOTS_DEF,
    parameter int POOL2_SLOTS = fbpa_pkg::POOL2_SLOTS_DEF,
    parameter int POOL3_SLOTS = fbpa_pkg::POOL3_SLOTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  fbpa_pkg::bm_cmd_t  cmd,
    output fbpa_pkg::bm_stat_t stat
);
    import fbpa_pkg::*;

    localparam logic [MAP_W-1:0] MASK [N_POOLS] = '{
        slot_mask(POOL0_SLOTS), slot_mask(POOL1_SLOTS),
        slot_mask(POOL2_SLOTS), slot_mask(POOL3_SLOTS)
    };

    logic [MAP_W-1:0] map_reg [N_POOLS];
    logic [MAP_W-1:0] row;

    // Slots past the pool's count read as used
    assign row = map_reg[cmd.pool] | ~MASK[cmd.pool];

    always_comb begin
        stat.full       = &row;
        stat.first_free = '0;
        for (int i = MAP_W - 1; i >= 0; i--) begin
            if (!row[i]) begin
                stat.first_free = SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < N_POOLS; p++) begin
                map_reg[p] <= '0;
            end
        end else if (cmd.set) begin
            map_reg[cmd.pool][cmd.slot] <= 1'b1;
        end else if (cmd.clr) begin
            map_reg[cmd.pool][cmd.slot] <= 1'b0;
        end
    end

endmodule

// ===== rtl/fixed_block_pool_allocator.sv =====
// Fixed block pool allocator: four pools of fixed-size blocks in one byte space.
// An allocation walks the pools in order, then forms the block address; a free walks
// the pools, then runs a five-step slot division; a free outside the pools ends after
// the walk, and a zero size goes straight to the result.
// One transaction at a time, s_ready high only while idle; the next transaction can
// be taken in the cycle after the result is loaded into the output register.
// Reset (synchronous, active low) frees every block and restores block sizes.
// Depends on fbpa_pkg, fbpa_muladd, fbpa_div and fbpa_bitmaps.
module fixed_block_pool_allocator #(
    parameter int POOL0_SLOTS = fbpa_pkg::POOL0_SLOTS_DEF,
    parameter int POOL1_SLOTS = fbpa_pkg::POOL1_SLOTS_DEF,
    parameter int POOL2_SLOTS = fbpa_pkg::POOL2_SLOTS_DEF,
    parameter int POOL3_SLOTS = fbpa_pkg::POOL3_SLOTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fbpa_pkg::BS_W-1:0]        cfg_wdata,
    // request channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_mode,
    input  logic [fbpa_pkg::SIZE_W-1:0]      s_request_size,
    input  logic [fbpa_pkg::ADDR_W-1:0]      s_release_address,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [fbpa_pkg::STATUS_W-1:0]    m_status,
    output logic [fbpa_pkg::ADDR_W-1:0]      m_block_address,
    output logic [fbpa_pkg::POOL_W-1:0]      m_pool_index,
    output logic [fbpa_pkg::SLOT_W-1:0]      m_slot_index
);
    import fbpa_pkg::*;

    // Sequencer states
    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_WALK       = 3'd1;
    localparam logic [2:0] ST_ALLOC_ADDR = 3'd2;
    localparam logic [2:0] ST_DIV        = 3'd3;
    localparam logic [2:0] ST_FINISH     = 3'd4;

    localparam logic [SLOT_CNT_W-1:0] SLOTS_A [N_POOLS] = '{
        SLOT_CNT_W'(POOL0_SLOTS), SLOT_CNT_W'(POOL1_SLOTS),
        SLOT_CNT_W'(POOL2_SLOTS), SLOT_CNT_W'(POOL3_SLOTS)
    };

    // Block size registers
    logic [BS_W-1:0] bs_reg [N_POOLS];

    // Sequencer and request context
    logic [2:0]          state_reg,  state_next;
    logic [POOL_W-1:0]   pool_reg,   pool_next;
    logic [BASE_W-1:0]   base_reg,   base_next;
    logic [SLOT_W-1:0]   slot_reg,   slot_next;
    logic                mode_reg,   mode_next;
    logic [SIZE_W-1:0]   size_reg,   size_next;
    logic [ADDR_W-1:0]   addr_reg,   addr_next;

    // Result being built
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ADDR_W-1:0]   res_addr_reg,   res_addr_next;
    logic [POOL_W-1:0]   res_pool_reg,   res_pool_next;
    logic [SLOT_W-1:0]   res_slot_reg,   res_slot_next;

    // Output register
    logic                m_valid_reg,   m_valid_next;
    logic [STATUS_W-1:0] m_status_reg,  m_status_next;
    logic [ADDR_W-1:0]   m_addr_reg,    m_addr_next;
    logic [POOL_W-1:0]   m_pool_reg,    m_pool_next;
    logic [SLOT_W-1:0]   m_slot_reg,    m_slot_next;

    // Shared unit, divider and bitmap hookups
    logic [SLOT_CNT_W-1:0] mac_count;
    logic [BS_W-1:0]       cur_bs;
    logic [BASE_W-1:0]     mac_sum;
    logic                  div_start;
    logic                  div_done;
    logic [SLOT_W-1:0]     div_quo;
    logic [ADDR_W-1:0]     div_rem;
    logic [ADDR_W-1:0]     div_offset;
    bm_cmd_t               bm_cmd;
    bm_stat_t              bm_stat;
    logic                  alloc_fit;
    logic                  free_hit;

    assign cur_bs     = bs_reg[pool_reg];
    // While walking, add this pool's length to get the next base;
    // for an allocation, add slot * block size to get the block address.
    assign mac_count  = (state_reg == ST_ALLOC_ADDR) ? {1'b0, slot_reg} : SLOTS_A[pool_reg];
    assign div_offset = addr_reg - base_reg[ADDR_W-1:0];

    fbpa_muladd u_muladd (
        .base       (base_reg),
        .count      (mac_count),
        .block_size (cur_bs),
        .sum        (mac_sum)
    );

    fbpa_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_offset),
        .divisor   (cur_bs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    fbpa_bitmaps #(
        .POOL0_SLOTS (POOL0_SLOTS),
        .POOL1_SLOTS (POOL1_SLOTS),
        .POOL2_SLOTS (POOL2_SLOTS),
        .POOL3_SLOTS (POOL3_SLOTS)
    ) u_bitmaps (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (bm_cmd),
        .stat    (bm_stat)
    );

    // A pool serves an allocation if it holds bytes, its blocks are large
    // enough and it still has a free slot.
    assign alloc_fit = (cur_bs != '0) && (size_reg <= cur_bs) && !bm_stat.full;
    // A free hits the pool whose [base, next base) range holds the address.
    assign free_hit  = (cur_bs != '0) && (BASE_W'(addr_reg) >= base_reg)
                     && (BASE_W'(addr_reg) < mac_sum);

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bs_reg[0] <= POOL0_BS_RST;
            bs_reg[1] <= POOL1_BS_RST;
            bs_reg[2] <= POOL2_BS_RST;
            bs_reg[3] <= POOL3_BS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_POOL0_BLOCK_SIZE: bs_reg[0] <= cfg_wdata;
                REG_POOL1_BLOCK_SIZE: bs_reg[1] <= cfg_wdata;
                REG_POOL2_BLOCK_SIZE: bs_reg[2] <= cfg_wdata;
                REG_POOL3_BLOCK_SIZE: bs_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next      = state_reg;
        pool_next       = pool_reg;
        base_next       = base_reg;
        slot_next       = slot_reg;
        mode_next       = mode_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_pool_next   = res_pool_reg;
        res_slot_next   = res_slot_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_addr_next     = m_addr_reg;
        m_pool_next     = m_pool_reg;
        m_slot_next     = m_slot_reg;
        div_start       = 1'b0;
        bm_cmd.set      = 1'b0;
        bm_cmd.clr      = 1'b0;
        bm_cmd.pool     = pool_reg;
        bm_cmd.slot     = slot_reg;

        // Drop the result once the consumer takes it
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mode_next       = s_mode;
                    size_next       = s_request_size;
                    addr_next       = s_release_address;
                    pool_next       = '0;
                    base_next       = '0;
                    res_status_next = STATUS_OK;
                    res_addr_next   = '0;
                    res_pool_next   = '0;
                    res_slot_next   = '0;
                    if (s_mode == MODE_ALLOC && s_request_size == '0) begin
                        res_status_next = STATUS_ZERO;
                        state_next      = ST_FINISH;
                    end else begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (mode_reg == MODE_ALLOC) begin
                    if (alloc_fit) begin
                        slot_next  = bm_stat.first_free;
                        state_next = ST_ALLOC_ADDR;
                    end else if (pool_reg == LAST_POOL) begin
                        res_status_next = STATUS_NOFIT;
                        state_next      = ST_FINISH;
                    end else begin
                        pool_next = pool_reg + 1'b1;
                        base_next = mac_sum;
                    end
                end else begin
                    if (free_hit) begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end else if (pool_reg == LAST_POOL) begin
                        res_status_next = STATUS_RANGE;
                        state_next      = ST_FINISH;
                    end else begin
                        pool_next = pool_reg + 1'b1;
                        base_next = mac_sum;
                    end
                end
            end
            ST_ALLOC_ADDR: begin
                // Mark the slot used; block address wraps to the address width
                bm_cmd.set    = 1'b1;
                res_addr_next = mac_sum[ADDR_W-1:0];
                res_pool_next = pool_reg;
                res_slot_next = slot_reg;
                state_next    = ST_FINISH;
            end
            ST_DIV: begin
                if (div_done) begin
                    // Clear the slot; the block starts at the address less the remainder
                    bm_cmd.clr    = 1'b1;
                    bm_cmd.slot   = div_quo;
                    res_addr_next = addr_reg - div_rem;
                    res_pool_next = pool_reg;
                    res_slot_next = div_quo;
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // Hold here until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_addr_next   = res_addr_reg;
                    m_pool_next   = res_pool_reg;
                    m_slot_next   = res_slot_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pool_reg       <= pool_next;
        base_reg       <= base_next;
        slot_reg       <= slot_next;
        mode_reg       <= mode_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_pool_reg   <= res_pool_next;
        res_slot_reg   <= res_slot_next;
        m_status_reg   <= m_status_next;
        m_addr_reg     <= m_addr_next;
        m_pool_reg     <= m_pool_next;
        m_slot_reg     <= m_slot_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_block_address = m_addr_reg;
    assign m_pool_index    = m_pool_reg;
    assign m_slot_index    = m_slot_reg;

    // In the cycle after an accepted transaction, the sequencer is no longer idle
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("sequencer stayed idle after accepting a transaction");

    // A successful result names a slot inside its pool
    a_slot_in_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STATUS_OK) |->
        ({1'b0, m_slot_index} < SLOTS_A[m_pool_index]))
        else $error("result slot beyond pool slot count");

    // Error results carry zero address, pool and slot
    a_error_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STATUS_OK) |->
        (m_block_address == '0 && m_pool_index == '0 && m_slot_index == '0))
        else $error("error result with nonzero fields");

    // Address generation only follows an allocate, division only a free
    a_mode_path: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_ALLOC_ADDR) |-> (mode_reg == MODE_ALLOC)) and
        ((state_reg == ST_DIV) |-> (mode_reg == MODE_FREE)))
        else $error("sequencer path does not match request kind");

endmodule
